### rtl/srp_pkg.sv
// ----------------------------------------------------------------------------
// srp_pkg
// Shared types and constants for the shelf rectangle packer: field widths,
// result status codes, default sizes and the layout of one shelf entry.
// ----------------------------------------------------------------------------
package srp_pkg;

  // width of every coordinate and size field
  localparam int unsigned FIELD_W = 11;
  // width of sums of two fields
  localparam int unsigned SUM_W   = FIELD_W + 1;

  // defaults for the top-level parameters
  localparam int unsigned DEF_ATLAS_SIZE  = 1024;
  localparam int unsigned DEF_MAX_SHELVES = 64;

  // result status codes
  typedef logic [1:0] status_t;
  localparam status_t STATUS_PLACED     = 2'd0;
  localparam status_t STATUS_ATLAS_FULL = 2'd1;
  localparam status_t STATUS_TABLE_FULL = 2'd2;

  typedef logic [FIELD_W-1:0] field_t;

  // one shelf table entry
  typedef struct packed {
    field_t fill_x;
    field_t top_y;
    field_t height;
  } shelf_t;

endpackage

### rtl/shelf_rect_packer.sv
// ----------------------------------------------------------------------------
// shelf_rect_packer
// Best-height-fit shelf packer for a square atlas, one rectangle per request.
// ----------------------------------------------------------------------------
// Each request carries a rectangle width and height and yields one result:
// a status (placed, atlas full, shelf table full) and the top-left corner of
// the placed rectangle, or 0,0 when it was not placed. The shelf table lives
// in a memory with one write and one read port that is scanned one shelf per cycle
// through one shared fit/compare unit; the decided result then waits in the
// emit step while out_stall holds the output register. Only one request is
// worked on at a time; in_stall stays high until its result has been loaded
// into the output register. The shelf memory needs no clearing after reset:
// only entries below the shelf count are ever judged.
// ----------------------------------------------------------------------------
module shelf_rect_packer #(
  parameter int unsigned ATLAS_SIZE  = srp_pkg::DEF_ATLAS_SIZE,
  parameter int unsigned MAX_SHELVES = srp_pkg::DEF_MAX_SHELVES
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // request channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [srp_pkg::FIELD_W-1:0] in_rect_width,
  input  logic [srp_pkg::FIELD_W-1:0] in_rect_height,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  out_status,
  output logic [srp_pkg::FIELD_W-1:0] out_pos_x,
  output logic [srp_pkg::FIELD_W-1:0] out_pos_y
);
  import srp_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_SHELVES + 1);
  localparam int unsigned IDX_W = $clog2(MAX_SHELVES);

  localparam logic [SUM_W-1:0] ATLAS_S  = SUM_W'(ATLAS_SIZE);
  localparam logic [SUM_W:0]   ATLAS_S2 = (SUM_W + 1)'(ATLAS_SIZE);
  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_SHELVES);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  // sequencer states
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_DECIDE = 2'd2;
  localparam logic [1:0] ST_EMIT   = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] shelf_count_r, shelf_count_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic             pend_r, pend_nxt;
  logic             pend_last_r, pend_last_nxt;
  logic             found_r, found_nxt;
  logic [IDX_W-1:0] best_idx_r, best_idx_nxt;
  field_t           best_h_r, best_h_nxt;
  field_t           best_x_r, best_x_nxt;
  field_t           best_y_r, best_y_nxt;
  logic [SUM_W-1:0] last_ny_r, last_ny_nxt;
  field_t           w_r, w_nxt;
  field_t           h_r, h_nxt;

  // decided result and table update
  status_t          res_status_r, res_status_nxt;
  field_t           res_x_r, res_x_nxt;
  field_t           res_y_r, res_y_nxt;
  logic             we_r, we_nxt;
  logic [IDX_W-1:0] waddr_r, waddr_nxt;
  shelf_t           wdata_r, wdata_nxt;
  logic             cnt_inc_r, cnt_inc_nxt;

  // output register
  logic             out_valid_r, out_valid_nxt;
  status_t          out_status_r, out_status_nxt;
  field_t           out_x_r, out_x_nxt;
  field_t           out_y_r, out_y_nxt;

  // shelf memory
  shelf_t           shelf_mem [MAX_SHELVES];
  shelf_t           rd_data_r;
  logic             mem_we;

  logic             accept;
  logic             out_free;
  logic [SUM_W-1:0] fit_x_sum;
  logic [SUM_W-1:0] fit_y_sum;
  logic             fits;
  logic [SUM_W:0]   new_bottom;
  logic [SUM_W-1:0] adv_x;
  logic [CNT_W-1:0] judge_idx;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign mem_we   = (state_r == ST_EMIT) && out_free && we_r;

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_pos_x  = out_x_r;
  assign out_pos_y  = out_y_r;

  // shared fit unit: one shelf against the current rectangle
  assign fit_x_sum = {1'b0, rd_data_r.fill_x} + {1'b0, w_r};
  assign fit_y_sum = {1'b0, rd_data_r.top_y} + {1'b0, h_r};
  assign fits = (fit_x_sum <= ATLAS_S) && (fit_y_sum <= ATLAS_S) &&
                (rd_data_r.height >= h_r) &&
                (!found_r || (rd_data_r.height < best_h_r));

  // index of the shelf being judged, one behind the read index
  assign judge_idx = idx_r - CNT_ONE;

  // bottom of a new shelf under the last one, and advanced fill x
  assign new_bottom = {1'b0, last_ny_r} + {2'b00, h_r};
  assign adv_x      = {1'b0, best_x_r} + {1'b0, w_r};

  // shelf memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      shelf_mem[waddr_r] <= wdata_r;
    end
    rd_data_r <= shelf_mem[idx_r[IDX_W-1:0]];
  end

  // sequencer and datapath next state
  always_comb begin
    state_nxt       = state_r;
    shelf_count_nxt = shelf_count_r;
    idx_nxt         = idx_r;
    pend_nxt        = pend_r;
    pend_last_nxt   = pend_last_r;
    found_nxt       = found_r;
    best_idx_nxt    = best_idx_r;
    best_h_nxt      = best_h_r;
    best_x_nxt      = best_x_r;
    best_y_nxt      = best_y_r;
    last_ny_nxt     = last_ny_r;
    w_nxt           = w_r;
    h_nxt           = h_r;
    res_status_nxt  = res_status_r;
    res_x_nxt       = res_x_r;
    res_y_nxt       = res_y_r;
    we_nxt          = we_r;
    waddr_nxt       = waddr_r;
    wdata_nxt       = wdata_r;
    cnt_inc_nxt     = cnt_inc_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_status_nxt  = out_status_r;
    out_x_nxt       = out_x_r;
    out_y_nxt       = out_y_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          w_nxt     = in_rect_width;
          h_nxt     = in_rect_height;
          idx_nxt   = '0;
          pend_nxt  = 1'b0;
          found_nxt = 1'b0;
          state_nxt = ST_SCAN;
        end
      end

      ST_SCAN: begin
        // issue the next shelf read
        if (idx_r < shelf_count_r) begin
          pend_nxt      = 1'b1;
          pend_last_nxt = (idx_r == shelf_count_r - CNT_ONE);
          idx_nxt       = idx_r + CNT_ONE;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            state_nxt = ST_DECIDE;
          end
        end
        // judge the shelf read in the previous cycle
        if (pend_r) begin
          if (fits) begin
            found_nxt    = 1'b1;
            best_idx_nxt = judge_idx[IDX_W-1:0];
            best_h_nxt   = rd_data_r.height;
            best_x_nxt   = rd_data_r.fill_x;
            best_y_nxt   = rd_data_r.top_y;
          end
          if (pend_last_r) begin
            last_ny_nxt = {1'b0, rd_data_r.top_y} + {1'b0, rd_data_r.height};
          end
        end
      end

      ST_DECIDE: begin
        res_status_nxt = STATUS_PLACED;
        res_x_nxt      = '0;
        res_y_nxt      = '0;
        we_nxt         = 1'b0;
        cnt_inc_nxt    = 1'b0;
        waddr_nxt      = best_idx_r;
        wdata_nxt      = '{fill_x: adv_x[FIELD_W-1:0], top_y: best_y_r, height: best_h_r};
        priority if (shelf_count_r == '0) begin
          // empty table: first shelf at the origin
          we_nxt      = 1'b1;
          cnt_inc_nxt = 1'b1;
          waddr_nxt   = '0;
          wdata_nxt   = '{fill_x: w_r, top_y: '0, height: h_r};
        end else if (found_r) begin
          we_nxt    = 1'b1;
          res_x_nxt = best_x_r;
          res_y_nxt = best_y_r;
        end else if (new_bottom > ATLAS_S2) begin
          res_status_nxt = STATUS_ATLAS_FULL;
        end else if (shelf_count_r >= CNT_MAX) begin
          res_status_nxt = STATUS_TABLE_FULL;
        end else begin
          // open a new shelf under the last one
          we_nxt      = 1'b1;
          cnt_inc_nxt = 1'b1;
          waddr_nxt   = shelf_count_r[IDX_W-1:0];
          wdata_nxt   = '{fill_x: w_r, top_y: last_ny_r[FIELD_W-1:0], height: h_r};
          res_y_nxt   = last_ny_r[FIELD_W-1:0];
        end
        state_nxt = ST_EMIT;
      end

      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_x_nxt      = res_x_r;
          out_y_nxt      = res_y_r;
          if (cnt_inc_r) begin
            shelf_count_nxt = shelf_count_r + CNT_ONE;
          end
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      shelf_count_r <= '0;
      pend_r        <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      shelf_count_r <= shelf_count_nxt;
      pend_r        <= pend_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // payload and scan registers
  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    pend_last_r  <= pend_last_nxt;
    found_r      <= found_nxt;
    best_idx_r   <= best_idx_nxt;
    best_h_r     <= best_h_nxt;
    best_x_r     <= best_x_nxt;
    best_y_r     <= best_y_nxt;
    last_ny_r    <= last_ny_nxt;
    w_r          <= w_nxt;
    h_r          <= h_nxt;
    res_status_r <= res_status_nxt;
    res_x_r      <= res_x_nxt;
    res_y_r      <= res_y_nxt;
    we_r         <= we_nxt;
    waddr_r      <= waddr_nxt;
    wdata_r      <= wdata_nxt;
    cnt_inc_r    <= cnt_inc_nxt;
    out_status_r <= out_status_nxt;
    out_x_r      <= out_x_nxt;
    out_y_r      <= out_y_nxt;
  end

  // shelf count stays within the table
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    shelf_count_r <= CNT_MAX)
    else $error("shelf count above table size");

  // shelf count grows by at most one per request
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n |=> (shelf_count_r == $past(shelf_count_r)) ||
              (shelf_count_r == $past(shelf_count_r) + CNT_ONE))
    else $error("shelf count jumped");

  // an accepted request blocks the next one
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> in_stall)
    else $error("request accepted while busy");

  // a new result appears only out of the emit step
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r)) |-> $past(state_r == ST_EMIT))
    else $error("result without emit");

  // unplaced results carry no position
  a_unplaced_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != STATUS_PLACED)) |->
      (out_x_r == '0) && (out_y_r == '0))
    else $error("unplaced result carries a position");

endmodule

### tb/shelf_rect_packer_test.sv
// ----------------------------------------------------------------------------
// shelf_rect_packer_test
// Self-checking bench for the shelf packer. A clocked driver feeds rectangle
// requests from a queue and a clocked monitor checks each result against a
// best-height-fit shelf table kept alongside the block. A short hand-picked
// sequence is followed by random rectangles under several idle/stall mixes.
// The atlas first fills with short shelves, so the shelf table runs out, and
// then with tall rectangles, so the atlas height runs out.
// ----------------------------------------------------------------------------
module shelf_rect_packer_test;
  import srp_pkg::*;

  localparam int unsigned ATLAS       = DEF_ATLAS_SIZE;
  localparam int unsigned SHELF_SLOTS = DEF_MAX_SHELVES;
  localparam int unsigned RANDOM_RECTS = 1450;
  // random rectangles from this index on may be tall
  localparam int unsigned TALL_START   = 1000;
  localparam int unsigned DRAIN_CYCLES = 80;

  typedef struct packed {
    field_t width;
    field_t height;
  } rect_t;

  typedef struct packed {
    status_t status;
    field_t  pos_x;
    field_t  pos_y;
  } placement_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  field_t     in_rect_width = '0;
  field_t     in_rect_height = '0;
  logic       out_stall = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [1:0] out_status;
  field_t     out_pos_x;
  field_t     out_pos_y;

  // shelf table as the block should hold it
  field_t      shelf_fill_x [SHELF_SLOTS];
  field_t      shelf_top_y  [SHELF_SLOTS];
  field_t      shelf_height [SHELF_SLOTS];
  int unsigned shelf_count = 0;

  rect_t      pending_rects[$];
  placement_t expected_placements[$];

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned error_count = 0;
  int unsigned results_checked = 0;
  int unsigned directed_count = 0;
  int unsigned placed_count = 0;
  int unsigned atlas_full_count = 0;
  int unsigned table_full_count = 0;

  shelf_rect_packer uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_rect_width  (in_rect_width),
    .in_rect_height (in_rect_height),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_pos_x      (out_pos_x),
    .out_pos_y      (out_pos_y)
  );

  always #10 clk = ~clk;

  // hold reset low at the start, then release it
  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
  end

  task automatic report_error(input string msg);
    $display("ERROR: %s", msg);
    error_count++;
  endtask

  task automatic queue_rect(input field_t w, input field_t h);
    rect_t r;
    r.width = w;
    r.height = h;
    pending_rects.push_back(r);
  endtask

  task automatic wait_sent();
    while (pending_rects.size() != 0 || in_valid) @(posedge clk);
  endtask

  // best-height fit: place one rectangle and update the shelf table
  function automatic placement_t place_rect(input field_t w, input field_t h);
    placement_t  result;
    int unsigned n, ny, best_h;
    int          best;
    result.status = STATUS_PLACED;
    result.pos_x = '0;
    result.pos_y = '0;
    n = shelf_count;
    best = -1;
    best_h = 0;
    // empty table: first shelf at the origin, no bounds check
    if (n == 0) begin
      shelf_fill_x[0] = w;
      shelf_top_y[0] = '0;
      shelf_height[0] = h;
      shelf_count = 1;
      return result;
    end
    // lowest qualifying shelf, first one on a tie
    for (int i = 0; i < n; i++) begin
      if (32'(shelf_fill_x[i]) + w <= ATLAS && 32'(shelf_top_y[i]) + h <= ATLAS &&
          shelf_height[i] >= h && (best < 0 || shelf_height[i] < best_h)) begin
        best = i;
        best_h = shelf_height[i];
      end
    end
    if (best >= 0) begin
      result.pos_x = shelf_fill_x[best];
      result.pos_y = shelf_top_y[best];
      shelf_fill_x[best] = shelf_fill_x[best] + w;
      return result;
    end
    // open a shelf below the last one if the atlas and the table allow it
    ny = 32'(shelf_top_y[n-1]) + shelf_height[n-1];
    if (ny + h > ATLAS) begin
      result.status = STATUS_ATLAS_FULL;
    end else if (n >= SHELF_SLOTS) begin
      result.status = STATUS_TABLE_FULL;
    end else begin
      shelf_fill_x[n] = w;
      shelf_top_y[n] = field_t'(ny);
      shelf_height[n] = h;
      shelf_count = n + 1;
      result.pos_y = field_t'(ny);
    end
    return result;
  endfunction

  // request driver: predict on acceptance, then load the next request
  always @(posedge clk) begin : drive_requests
    rect_t next_rect;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        expected_placements.push_back(place_rect(in_rect_width, in_rect_height));
      end
      if (pending_rects.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_rect = pending_rects.pop_front();
        in_valid <= 1'b1;
        in_rect_width <= next_rect.width;
        in_rect_height <= next_rect.height;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result monitor: compare against the oldest prediction, random stall
  always @(posedge clk) begin : check_results
    placement_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_placements.size() == 0) begin
          report_error($sformatf("result with none expected: status %0d at %0d,%0d",
                                 out_status, out_pos_x, out_pos_y));
        end else begin
          want = expected_placements.pop_front();
          if (out_status !== want.status)
            report_error($sformatf("result %0d: status %0d, expected %0d",
                                   results_checked, out_status, want.status));
          if (out_pos_x !== want.pos_x)
            report_error($sformatf("result %0d: pos_x %0d, expected %0d",
                                   results_checked, out_pos_x, want.pos_x));
          if (out_pos_y !== want.pos_y)
            report_error($sformatf("result %0d: pos_y %0d, expected %0d",
                                   results_checked, out_pos_y, want.pos_y));
          case (want.status)
            STATUS_PLACED:     placed_count++;
            STATUS_ATLAS_FULL: atlas_full_count++;
            default:           table_full_count++;
          endcase
        end
        results_checked++;
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // stimulus, phases and end of run
  initial begin : stimulus
    int unsigned phase_idle [4];
    int unsigned phase_stall [4];
    int unsigned roll, k, phase_len;
    field_t      w, h;
    phase_idle  = '{0, 46, 0, 36};
    phase_stall = '{0, 0, 46, 36};
    k = 0;

    // first shelf spans the full width
    queue_rect(11'd1024, 11'd8);
    // zero width at the right edge, then zero size
    queue_rect(11'd0, 11'd8);
    queue_rect(11'd0, 11'd0);
    // new shelves and placement on them
    queue_rect(11'd1, 11'd8);
    queue_rect(11'd10, 11'd8);
    queue_rect(11'd5, 11'd4);
    queue_rect(11'd20, 11'd12);
    // lower shelf preferred over a taller one
    queue_rect(11'd3, 11'd8);
    // second shelf of equal height, then a tie goes to the first
    queue_rect(11'd1010, 11'd8);
    queue_rect(11'd4, 11'd8);
    // too tall for the atlas, once at the full atlas height and once just under it
    queue_rect(11'd7, 11'd1024);
    queue_rect(11'd5, 11'd1000);
    // full-width shelf of zero height, then best fit onto it
    queue_rect(11'd1024, 11'd0);
    queue_rect(11'd0, 11'd0);
    queue_rect(11'd30, 11'd12);
    // new shelf right below a zero-height shelf
    queue_rect(11'd994, 11'd12);
    queue_rect(11'd1, 11'd1);
    // fill a shelf to exactly the right edge, then overflow it by one
    queue_rect(11'd1023, 11'd1);
    queue_rect(11'd1, 11'd1);
    queue_rect(11'd1, 11'd1);
    queue_rect(11'd1024, 11'd1024);
    queue_rect(11'd512, 11'd976);
    directed_count = pending_rects.size();
    wait_sent();

    // random rectangles: short ones fill the shelf table, tall ones the atlas
    for (int p = 0; p < 4; p++) begin
      @(negedge clk);
      send_idle_pct = phase_idle[p];
      stall_pct = phase_stall[p];
      phase_len = (p == 3) ? RANDOM_RECTS - 3 * (RANDOM_RECTS / 4) : RANDOM_RECTS / 4;
      for (int j = 0; j < phase_len; j++) begin
        roll = $urandom_range(99);
        if (roll < 3)       w = '0;
        else if (roll < 83) w = field_t'($urandom_range(40, 1));
        else if (roll < 95) w = field_t'($urandom_range(300, 41));
        else if (roll < 99) w = field_t'($urandom_range(1023, 301));
        else                w = field_t'(ATLAS);
        roll = $urandom_range(99);
        if (k < TALL_START) begin
          if (roll < 8)       h = '0;
          else if (roll < 95) h = field_t'($urandom_range(12, 1));
          else                h = field_t'($urandom_range(16, 13));
        end else begin
          if (roll < 50)      h = field_t'($urandom_range(16, 0));
          else if (roll < 80) h = field_t'($urandom_range(200, 17));
          else if (roll < 97) h = field_t'($urandom_range(1023, 201));
          else                h = field_t'(ATLAS);
        end
        queue_rect(w, h);
        k++;
      end
      wait_sent();
    end

    // drain outstanding results, then let the block settle
    while (expected_placements.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d directed and %0d random rectangles, %0d results checked",
             directed_count, k, results_checked);
    $display("placed %0d, atlas full %0d, shelf table full %0d, %0d shelves open",
             placed_count, atlas_full_count, table_full_count, shelf_count);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // hang guard
  initial begin
    #20_000_000;
    $display("timeout: %0d results still outstanding", expected_placements.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
